/* rtl/hsu_pkg.sv */
`default_nettype none

package hsu_pkg;

    // Width of one stored value and of the request value field.
    localparam int unsigned VALUE_W = 32;

    // Defaults for the top-level parameters.
    localparam int unsigned BUCKETS_DEF = 1024;
    localparam int unsigned WAYS_DEF    = 4;

    localparam int unsigned STATUS_W = 3;

    // Request opcodes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Response codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_CMP   = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hash_done;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/hsu_if.sv */
`default_nettype none

interface hsu_req_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic signed [hsu_pkg::VALUE_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface hsu_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [hsu_pkg::STATUS_W-1:0] status;

    modport source (output valid, output status, input ready);
    modport sink (input valid, input status, output ready);
endinterface

`default_nettype wire

/* rtl/hsu_div.sv */
`default_nettype none

// Bucket index unit: remainder of a magnitude by BUCKETS. A power-of-two
// bucket count is a mask. Any other count takes a quotient estimate from a
// multiply by the reciprocal of the count, subtracts the estimate times the
// count and corrects the result with one compare and subtract. These run in
// order through the magnitude, quotient, partial remainder and remainder
// registers, and done is registered with the remainder.
module hsu_div #(
    parameter int unsigned BUCKETS = hsu_pkg::BUCKETS_DEF,
    localparam int unsigned AW = $clog2(BUCKETS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hsu_pkg::VALUE_W-1:0] mag,
    output logic [AW-1:0]               rem,
    output logic                        done
);

    localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    generate
        if (POW2)
        begin : g_mask
            logic [AW-1:0] rem_reg;
            logic          done_reg;

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= mag[AW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else if (start)
                begin
                    done_reg <= 1'b1;
                end
            end

            assign rem  = rem_reg;
            assign done = done_reg;
        end
        else
        begin : g_recip
            localparam int unsigned VW = hsu_pkg::VALUE_W;
            // The reciprocal is rounded down, so the estimate is the true
            // quotient or one less and one correcting subtract is enough.
            localparam logic [VW-1:0] RECIP   = VW'((64'd1 << VW) / BUCKETS);
            localparam logic [VW-1:0] DIVISOR = VW'(BUCKETS);

            logic [VW-1:0]   mag_reg;
            logic [2*VW-1:0] prod;
            logic [VW-1:0]   quot_reg;
            logic [VW-1:0]   part_reg;
            logic [VW-1:0]   part_next;
            logic [AW-1:0]   rem_reg;
            logic [2:0]      stage_reg;
            logic            done_reg;

            always_comb
            begin
                prod      = {{VW{1'b0}}, mag_reg} * {{VW{1'b0}}, RECIP};
                part_next = (part_reg >= DIVISOR) ? (part_reg - DIVISOR) : part_reg;
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    mag_reg <= mag;
                end
                if (stage_reg[0])
                begin
                    quot_reg <= prod[2*VW-1:VW];
                end
                if (stage_reg[1])
                begin
                    part_reg <= mag_reg - quot_reg * DIVISOR;
                end
                if (stage_reg[2])
                begin
                    rem_reg <= part_next[AW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg <= '0;
                    done_reg  <= 1'b0;
                end
                else if (start)
                begin
                    stage_reg <= 3'b001;
                    done_reg  <= 1'b0;
                end
                else
                begin
                    stage_reg <= {stage_reg[1:0], 1'b0};
                    if (stage_reg[2])
                    begin
                        done_reg <= 1'b1;
                    end
                end
            end

            assign rem  = rem_reg;
            assign done = done_reg;
        end
    endgenerate

endmodule

`default_nettype wire

/* rtl/hsu_dp.sv */
`default_nettype none

// Datapath: request registers, bucket index unit, bucket memories, way
// compare, write back and the response register.
module hsu_dp #(
    parameter int unsigned BUCKETS = hsu_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS    = hsu_pkg::WAYS_DEF,
    localparam int unsigned AW = $clog2(BUCKETS)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hsu_pkg::cmd_t                      cmd,
    output hsu_pkg::sts_t                      sts,
    input  logic                               req_opcode,
    input  logic signed [hsu_pkg::VALUE_W-1:0] req_value,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [hsu_pkg::STATUS_W-1:0]       rsp_status
);

    localparam logic [AW-1:0] CLR_LAST = AW'(BUCKETS - 1);

    logic [WAYS-1:0]                       valid_mem [BUCKETS];
    logic [WAYS-1:0][hsu_pkg::VALUE_W-1:0] value_mem [BUCKETS];

    logic                                  op_reg;
    logic [hsu_pkg::VALUE_W-1:0]           value_reg;
    logic [hsu_pkg::VALUE_W-1:0]           value_bits;
    logic [hsu_pkg::VALUE_W-1:0]           value_mag;
    logic [AW-1:0]                         bucket;
    logic                                  hash_done;

    logic [WAYS-1:0]                       rd_valid_reg;
    logic [WAYS-1:0][hsu_pkg::VALUE_W-1:0] rd_value_reg;

    logic [WAYS-1:0]                       hit_vec;
    logic [WAYS-1:0]                       free_vec;
    logic [WAYS-1:0]                       sel_vec;
    logic                                  hit;
    logic                                  full;
    logic                                  do_write;
    logic [WAYS-1:0]                       valid_row_next;
    logic [WAYS-1:0][hsu_pkg::VALUE_W-1:0] value_row_next;
    logic [AW-1:0]                         valid_wr_addr;
    hsu_pkg::status_t                      status_next;

    logic [AW-1:0]                         clr_cnt_reg;
    logic                                  out_valid_reg;
    hsu_pkg::status_t                      status_reg;

    // Magnitude of the value; the most negative value maps onto itself as
    // an unsigned number.
    always_comb
    begin
        value_bits = $unsigned(req_value);
        value_mag  = value_bits[hsu_pkg::VALUE_W-1] ? (~value_bits + 1'b1) : value_bits;
    end

    hsu_div #(
        .BUCKETS (BUCKETS)
    ) u_hsu_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .mag   (value_mag),
        .rem   (bucket),
        .done  (hash_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= req_opcode;
            value_reg <= value_bits;
        end
    end

    // Way compare and free-slot pick on the registered bucket row.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w]        = rd_valid_reg[w] && (rd_value_reg[w] == value_reg);
        end
        free_vec = ~rd_valid_reg;
        sel_vec  = free_vec & (~free_vec + 1'b1);
        hit      = |hit_vec;
        full     = &rd_valid_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            value_row_next[w] = sel_vec[w] ? value_reg : rd_value_reg[w];
        end
        valid_row_next = rd_valid_reg | sel_vec;

        if (op_reg == hsu_pkg::OP_SEARCH)
        begin
            status_next = hit ? hsu_pkg::ST_PRESENT : hsu_pkg::ST_ABSENT;
        end
        else if (hit)
        begin
            status_next = hsu_pkg::ST_DUPLICATE;
        end
        else if (full)
        begin
            status_next = hsu_pkg::ST_FULL;
        end
        else
        begin
            status_next = hsu_pkg::ST_INSERTED;
        end

        do_write      = cmd.commit && (op_reg == hsu_pkg::OP_INSERT) && !hit && !full;
        valid_wr_addr = cmd.clear ? clr_cnt_reg : bucket;
    end

    // Valid marks: cleared row by row after reset, read every cycle at the
    // current bucket.
    always_ff @(posedge clk)
    begin
        if (cmd.clear || do_write)
        begin
            valid_mem[valid_wr_addr] <= cmd.clear ? '0 : valid_row_next;
        end
        rd_valid_reg <= valid_mem[bucket];
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            value_mem[bucket] <= value_row_next;
        end
        rd_value_reg <= value_mem[bucket];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= status_next;
        end
    end

    assign sts.hash_done = hash_done;
    assign sts.clr_last  = (clr_cnt_reg == CLR_LAST);
    assign sts.out_free  = !out_valid_reg || rsp_ready;

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = status_reg;

endmodule

`default_nettype wire

/* rtl/hsu_ctrl.sv */
`default_nettype none

// Sequencer: clearing pass, request accept, hashing wait, compare and commit.
module hsu_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  hsu_pkg::sts_t sts,
    output hsu_pkg::cmd_t cmd
);

    hsu_pkg::state_t state_reg;
    hsu_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            hsu_pkg::S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = hsu_pkg::S_IDLE;
                end
            end
            hsu_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = hsu_pkg::S_HASH;
                end
            end
            hsu_pkg::S_HASH:
            begin
                if (sts.hash_done)
                begin
                    state_next = hsu_pkg::S_CMP;
                end
            end
            hsu_pkg::S_CMP:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = hsu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hsu_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsu_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/hashed_integer_set_unit.sv */
`default_nettype none

// Channel  Role    Payload                    Meaning
// req      sink    opcode[0], value[31:0] s   0 insert value, 1 search for value
// rsp      source  status[2:0]                0 inserted, 1 duplicate, 2 present,
//                                             3 absent, 4 bucket full
//
// One request is worked on at a time. With a power-of-two BUCKETS a request
// passes from accept to the next accept through bucket index, registered
// bucket read, compare and write back. Any other BUCKETS forms the bucket
// index by a reciprocal multiply, a multiply and subtract and one correcting
// subtract.
// After reset the valid marks are cleared one bucket per cycle, so req.ready
// stays low until every bucket has been cleared.
// A response waits in an output register; the next request is accepted
// meanwhile and only its commit waits for rsp.ready.
module hashed_integer_set_unit #(
    parameter int unsigned BUCKETS = hsu_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS    = hsu_pkg::WAYS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hsu_req_if.sink   req,
    hsu_rsp_if.source rsp
);

    hsu_pkg::cmd_t cmd;
    hsu_pkg::sts_t sts;

    // The controller owns sequencing and the request handshake.
    hsu_ctrl u_hsu_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath owns the table, the compare and the response register.
    hsu_dp #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_hsu_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_opcode (req.opcode),
        .req_value  (req.value),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_status (rsp.status)
    );

endmodule

`default_nettype wire

/* rtl/hsu_checker.sv */
`default_nettype none

// Port-level checks: one response per request, at most one request beyond
// the one whose response is waiting.
module hsu_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [hsu_pkg::STATUS_W-1:0] rsp_status
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg + {1'b0, req_acc} - {1'b0, rsp_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status))
        else $error("response status changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("response without an outstanding request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> pending_reg <= 2'd1)
        else $error("request accepted with two requests outstanding");

endmodule

bind hashed_integer_set_unit hsu_checker u_hsu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status)
);

`default_nettype wire
